### rtl/bsef_pkg.sv
// shared types and constants of the button scroll event filter
package bsef_pkg;

	localparam int TYPE_W  = 5;
	localparam int CODE_W  = 10;
	localparam int VALUE_W = 32;
	localparam int SCALE_W = 4;
	localparam int CFG_W   = 10;
	localparam int IDX_W   = 1;
	localparam int SAT_W   = 8;
	localparam int ACC_W   = 12;
	localparam int REM_W   = 8;

	localparam logic [TYPE_W-1:0] TYPE_SYN = 5'd0;
	localparam logic [TYPE_W-1:0] TYPE_KEY = 5'd1;
	localparam logic [TYPE_W-1:0] TYPE_REL = 5'd2;
	localparam logic [TYPE_W-1:0] TYPE_MSC = 5'd4;

	localparam logic [CODE_W-1:0] CODE_X         = 10'd0;
	localparam logic [CODE_W-1:0] CODE_Y         = 10'd1;
	localparam logic [CODE_W-1:0] CODE_SCAN      = 10'd4;
	localparam logic [CODE_W-1:0] CODE_HWHEEL    = 10'd6;
	localparam logic [CODE_W-1:0] CODE_WHEEL     = 10'd8;
	localparam logic [CODE_W-1:0] CODE_WHEEL_HI  = 10'h0b;
	localparam logic [CODE_W-1:0] CODE_HWHEEL_HI = 10'h0c;

	localparam int DETENT       = 120;
	localparam int MOTION_LIMIT = 127;

	localparam logic [IDX_W-1:0] REG_SCALE   = 1'b0;
	localparam logic [IDX_W-1:0] REG_TRIGGER = 1'b1;

	localparam logic [SCALE_W-1:0] SCALE_RESET   = 4'd5;
	localparam logic [CODE_W-1:0]  TRIGGER_RESET = 10'd278;

	typedef enum logic [1:0] {
		SEL_HI,
		SEL_DET,
		SEL_FWD
	} bsef_sel_t;

	typedef struct packed {
		logic      ready;
		logic      load;
		logic      set_held;
		logic      mul;
		logic      emit;
		bsef_sel_t sel;
		logic      step_acc;
		logic      commit;
	} bsef_cmd_t;

	typedef struct packed {
		logic in_valid;
		logic is_trigger;
		logic is_scroll;
		logic is_fwd;
		logic hi_zero;
		logic acc_pos;
		logic acc_neg;
		logic out_free;
	} bsef_sts_t;

endpackage

### rtl/bsef_if.sv
// event channel interfaces for input items and result items

interface bsef_in_if;
	logic                              valid;
	logic                              ready;
	logic [bsef_pkg::TYPE_W-1:0]       event_type;
	logic [bsef_pkg::CODE_W-1:0]       event_code;
	logic signed [bsef_pkg::VALUE_W-1:0] event_value;

	modport source(output valid, output event_type, output event_code, output event_value,
		input ready);
	modport sink(input valid, input event_type, input event_code, input event_value,
		output ready);
endinterface

interface bsef_out_if;
	logic                              valid;
	logic                              ready;
	logic [bsef_pkg::TYPE_W-1:0]       out_type;
	logic [bsef_pkg::CODE_W-1:0]       out_code;
	logic signed [bsef_pkg::VALUE_W-1:0] out_value;
	logic                              last_in_run;

	modport source(output valid, output out_type, output out_code, output out_value,
		output last_in_run, input ready);
	modport sink(input valid, input out_type, input out_code, input out_value,
		input last_in_run, output ready);
endinterface

### rtl/bsef_ctrl.sv
// controller state machine that sequences one event through the datapath
module bsef_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  bsef_pkg::bsef_sts_t sts,
	output bsef_pkg::bsef_cmd_t cmd
);
	import bsef_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_HI,
		ST_DET,
		ST_FWD
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd     = '0;
		cmd.sel = SEL_FWD;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.ready = 1'b1;
				if (sts.in_valid) begin
					cmd.load     = 1'b1;
					cmd.set_held = sts.is_trigger;
					if (sts.is_scroll) begin
						state_d = ST_MUL;
					end else if (sts.is_fwd) begin
						state_d = ST_FWD;
					end
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_HI;
			end
			ST_HI: begin
				if (sts.hi_zero) begin
					state_d = ST_DET;
				end else if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = SEL_HI;
					state_d  = ST_DET;
				end
			end
			ST_DET: begin
				if (sts.acc_pos || sts.acc_neg) begin
					if (sts.out_free) begin
						cmd.emit     = 1'b1;
						cmd.sel      = SEL_DET;
						cmd.step_acc = 1'b1;
					end
				end else begin
					// remainder back in range, write it back
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_FWD: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.sel  = SEL_FWD;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### rtl/bsef_dp.sv
// datapath: config registers, scroll state, scaling, detent counting and output register
module bsef_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [bsef_pkg::IDX_W-1:0]   cfg_index,
	input  logic [bsef_pkg::CFG_W-1:0]   cfg_data,
	input  bsef_pkg::bsef_cmd_t          cmd,
	output bsef_pkg::bsef_sts_t          sts,
	bsef_in_if.sink                      events,
	bsef_out_if.source                   results
);
	import bsef_pkg::*;

	localparam logic signed [ACC_W-1:0]   DETENT_A = ACC_W'(DETENT);
	localparam logic signed [VALUE_W:0]   LIMIT_W  = (VALUE_W+1)'(MOTION_LIMIT);
	localparam logic signed [SAT_W-1:0]   LIMIT_S  = SAT_W'(MOTION_LIMIT);

	logic [SCALE_W-1:0]           scale_q;
	logic [CODE_W-1:0]            trig_q;
	logic                         held_q;
	logic signed [REM_W-1:0]      vrem_q;
	logic signed [REM_W-1:0]      hrem_q;

	logic [TYPE_W-1:0]            type_q;
	logic [CODE_W-1:0]            code_q;
	logic signed [VALUE_W-1:0]    value_q;
	logic                         vert_q;
	logic signed [SAT_W-1:0]      sat_q;
	logic signed [ACC_W-1:0]      hi_q;
	logic signed [ACC_W-1:0]      acc_q;

	logic                         out_valid_q;
	logic [TYPE_W-1:0]            out_type_q;
	logic [CODE_W-1:0]            out_code_q;
	logic signed [VALUE_W-1:0]    out_value_q;
	logic                         out_last_q;

	logic                         in_vert;
	logic signed [VALUE_W:0]      v_wide;
	logic signed [VALUE_W:0]      v_axis;
	logic signed [SAT_W-1:0]      v_sat;
	logic signed [ACC_W:0]        prod;
	logic signed [ACC_W-1:0]      rem_ext;
	logic signed [ACC_W-1:0]      acc_step;
	logic                         step_in_range;
	logic                         is_trigger;
	logic                         is_scroll;
	logic                         is_fwd;

	// classification of the item at the input
	assign is_trigger = (events.event_type == TYPE_KEY) && (events.event_code == trig_q);
	assign is_scroll  = !is_trigger && held_q && (events.event_type == TYPE_REL) &&
		((events.event_code == CODE_X) || (events.event_code == CODE_Y));
	assign is_fwd     = !is_trigger && !is_scroll &&
		((events.event_type == TYPE_SYN) || (events.event_type == TYPE_KEY) ||
		 (events.event_type == TYPE_REL) ||
		 ((events.event_type == TYPE_MSC) && (events.event_code == CODE_SCAN)));

	// y is negated at full width before saturation
	assign in_vert = (events.event_code == CODE_Y);
	assign v_wide  = {events.event_value[VALUE_W-1], events.event_value};
	assign v_axis  = in_vert ? -v_wide : v_wide;

	always_comb begin
		priority if (v_axis > LIMIT_W) begin
			v_sat = LIMIT_S;
		end else if (v_axis < -LIMIT_W) begin
			v_sat = -LIMIT_S;
		end else begin
			v_sat = v_axis[SAT_W-1:0];
		end
	end

	assign prod    = sat_q * $signed({1'b0, scale_q});
	assign rem_ext = vert_q ? ACC_W'(vrem_q) : ACC_W'(hrem_q);

	assign acc_step      = sts.acc_pos ? acc_q - DETENT_A : acc_q + DETENT_A;
	assign step_in_range = (acc_step < DETENT_A) && (acc_step > -DETENT_A);

	assign sts.in_valid   = events.valid;
	assign sts.is_trigger = is_trigger;
	assign sts.is_scroll  = is_scroll;
	assign sts.is_fwd     = is_fwd;
	assign sts.hi_zero    = (hi_q == '0);
	assign sts.acc_pos    = (acc_q >= DETENT_A);
	assign sts.acc_neg    = (acc_q <= -DETENT_A);
	assign sts.out_free   = !out_valid_q || results.ready;

	assign events.ready = cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
			trig_q  <= TRIGGER_RESET;
			held_q  <= 1'b0;
			vrem_q  <= '0;
			hrem_q  <= '0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_SCALE:   scale_q <= cfg_data[SCALE_W-1:0];
					REG_TRIGGER: trig_q  <= cfg_data[CODE_W-1:0];
					default: ;
				endcase
			end
			if (cmd.set_held) begin
				held_q <= (events.event_value != '0);
			end
			if (cmd.commit) begin
				if (vert_q) begin
					vrem_q <= acc_q[REM_W-1:0];
				end else begin
					hrem_q <= acc_q[REM_W-1:0];
				end
			end
		end
	end

	// item capture, scaling and running sum
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			type_q  <= events.event_type;
			code_q  <= events.event_code;
			value_q <= events.event_value;
			vert_q  <= in_vert;
			sat_q   <= v_sat;
		end
		if (cmd.mul) begin
			hi_q  <= prod[ACC_W-1:0];
			acc_q <= rem_ext + prod[ACC_W-1:0];
		end else if (cmd.step_acc) begin
			acc_q <= acc_step;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			case (cmd.sel)
				SEL_HI: begin
					out_type_q  <= TYPE_REL;
					out_code_q  <= vert_q ? CODE_WHEEL_HI : CODE_HWHEEL_HI;
					out_value_q <= VALUE_W'(hi_q);
					out_last_q  <= !sts.acc_pos && !sts.acc_neg;
				end
				SEL_DET: begin
					out_type_q  <= TYPE_REL;
					out_code_q  <= vert_q ? CODE_WHEEL : CODE_HWHEEL;
					out_value_q <= sts.acc_pos ? VALUE_W'(1) : -VALUE_W'(1);
					out_last_q  <= step_in_range;
				end
				default: begin
					out_type_q  <= type_q;
					out_code_q  <= code_q;
					out_value_q <= value_q;
					out_last_q  <= 1'b1;
				end
			endcase
		end
	end

	assign results.valid       = out_valid_q;
	assign results.out_type    = out_type_q;
	assign results.out_code    = out_code_q;
	assign results.out_value   = out_value_q;
	assign results.last_in_run = out_last_q;

	// remainders stay strictly inside one detent
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(vrem_q < REM_W'(DETENT)) && (vrem_q > -REM_W'(DETENT)) &&
		(hrem_q < REM_W'(DETENT)) && (hrem_q > -REM_W'(DETENT)))
		else $error("scroll remainder out of range");

	// a result is only loaded when the output register can take it
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result overwrites a pending item");

	// write-back only with a sum already reduced below one detent
	a_commit_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!sts.acc_pos && !sts.acc_neg))
		else $error("remainder committed before detents were drained");

endmodule

### rtl/button_scroll_event_filter_unit.sv
// top level of the button scroll event filter
//
// events: input channel of (event_type, event_code, event_value) items, valid/ready.
// results: output channel of (out_type, out_code, out_value, last_in_run) items;
//   last_in_run marks the final result caused by one input item.
// cfg_wr_en / cfg_index / cfg_data: register writes, index 0 scale, 1 trigger code;
//   to be written only while the block is idle; the block itself does not enforce this.
// sequence: a forwarded event is captured on acceptance and copied to the output
//   register once that is free. a scroll event is saturated on capture, then scaled,
//   then gives its results (at most 17: one hi-res event and up to 16 detents) and
//   finally stores its remainder.
// throughput: one item at a time; the next item is accepted only once the previous
//   one is finished.
//   the detent loop of the datapath gives one detent per cycle while the output is free.
// the output register decouples the sides: the next item is accepted while the last
//   result of the previous one still waits to be taken.
// receiver stall: results wait in the output register and the sequencer holds.
// reset: held flag and both remainders clear, scale returns to 5 and the
//   trigger code to 278; no result is pending.
module button_scroll_event_filter_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [bsef_pkg::IDX_W-1:0] cfg_index,
	input  logic [bsef_pkg::CFG_W-1:0] cfg_data,
	bsef_in_if.sink                    events,
	bsef_out_if.source                 results
);
	import bsef_pkg::*;

	// command and status between sequencer and datapath
	bsef_cmd_t cmd;
	bsef_sts_t sts;

	// state machine: accept, scale, hi-res event, detent loop, forward
	bsef_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	// datapath owns the channels, registers and remainders
	bsef_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.events    (events),
		.results   (results)
	);

endmodule
